FILE: design/slbm_pkg.sv
package slbm_pkg;

   localparam int PRG_ADDR_BITS = 19;
   localparam int CHR_ADDR_BITS = 17;
   localparam int MEM_ADDR_W    = 19;

   localparam logic [MEM_ADDR_W-1:0] PRG_MASK = MEM_ADDR_W'((1 << PRG_ADDR_BITS) - 1);
   localparam logic [16:0]           CHR_MASK = 17'((1 << CHR_ADDR_BITS) - 1);

   localparam logic [1:0] CMD_CPU_READ  = 2'd0;
   localparam logic [1:0] CMD_CPU_WRITE = 2'd1;
   localparam logic [1:0] CMD_PPU_READ  = 2'd2;
   localparam logic [1:0] CMD_PPU_WRITE = 2'd3;

   localparam logic [2:0] TGT_NONE      = 3'd0;
   localparam logic [2:0] TGT_PRG_ROM   = 3'd1;
   localparam logic [2:0] TGT_PRG_RAM   = 3'd2;
   localparam logic [2:0] TGT_NVRAM     = 3'd3;
   localparam logic [2:0] TGT_CHR       = 3'd4;
   localparam logic [2:0] TGT_NAMETABLE = 3'd5;
   localparam logic [2:0] TGT_OPEN_BUS  = 3'd6;
   localparam logic [2:0] TGT_MAPPER    = 3'd7;

   localparam logic [2:0] REG_PRG_ROM_BANKS   = 3'd0;
   localparam logic [2:0] REG_CHR_MASK        = 3'd1;
   localparam logic [2:0] REG_PRG_RAM_BANKS   = 3'd2;
   localparam logic [2:0] REG_PRG_NVRAM_BANKS = 3'd3;
   localparam logic [2:0] REG_RAM_LAYOUT      = 3'd4;

   localparam logic [1:0] SEL_CONTROL  = 2'd0;
   localparam logic [1:0] SEL_CHR_LOW  = 2'd1;
   localparam logic [1:0] SEL_CHR_HIGH = 2'd2;
   localparam logic [1:0] SEL_PRG_PAGE = 2'd3;

   localparam logic [4:0] CONTROL_RESET = 5'h0C;
   localparam logic [4:0] PRG_MODE_3    = 5'h0C;
   localparam logic [2:0] SHIFT_DONE    = 3'd5;

   typedef struct packed {
      logic [5:0] prg_rom_banks;
      logic [4:0] chr_mask;
      logic [2:0] prg_ram_banks;
      logic [2:0] prg_nvram_banks;
      logic       ram_layout;
   } cfg_type;

   typedef struct packed {
      logic [4:0] control;
      logic [4:0] chr_low;
      logic [4:0] chr_high;
      logic [4:0] prg_page;
   } bank_type;

   typedef struct packed {
      logic [1:0]  command;
      logic [15:0] address;
      logic [7:0]  data;
      logic [31:0] cycle;
   } access_type;

endpackage

FILE: design/slbm_csr.sv
module slbm_csr
   import slbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready,
   output cfg_type     cfg
);

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic [2:0] index;
   logic       wr_en;

   assign index      = csr_paddr[4:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;
   assign cfg        = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (index)
            REG_PRG_ROM_BANKS:   cfg_in.prg_rom_banks   = csr_pwdata[5:0];
            REG_CHR_MASK:        cfg_in.chr_mask        = csr_pwdata[4:0];
            REG_PRG_RAM_BANKS:   cfg_in.prg_ram_banks   = csr_pwdata[2:0];
            REG_PRG_NVRAM_BANKS: cfg_in.prg_nvram_banks = csr_pwdata[2:0];
            REG_RAM_LAYOUT:      cfg_in.ram_layout      = csr_pwdata[0];
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (index)
         REG_PRG_ROM_BANKS:   csr_prdata = {26'd0, cfg_ff.prg_rom_banks};
         REG_CHR_MASK:        csr_prdata = {27'd0, cfg_ff.chr_mask};
         REG_PRG_RAM_BANKS:   csr_prdata = {29'd0, cfg_ff.prg_ram_banks};
         REG_PRG_NVRAM_BANKS: csr_prdata = {29'd0, cfg_ff.prg_nvram_banks};
         REG_RAM_LAYOUT:      csr_prdata = {31'd0, cfg_ff.ram_layout};
         default:             csr_prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.prg_rom_banks   <= 6'd2;
         cfg_ff.chr_mask        <= 5'd1;
         cfg_ff.prg_ram_banks   <= 3'd1;
         cfg_ff.prg_nvram_banks <= 3'd0;
         cfg_ff.ram_layout      <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: design/slbm_bank_regs.sv
module slbm_bank_regs
   import slbm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       step,
   input  access_type access,
   output bank_type   banks,
   output logic [4:0] control_next,
   output logic       loaded
);

   bank_type    banks_ff;
   bank_type    banks_in;
   logic [4:0]  shift_ff;
   logic [4:0]  shift_in;
   logic [2:0]  count_ff;
   logic [2:0]  count_in;
   logic [31:0] last_ff;
   logic [31:0] last_in;
   logic        serial_write;
   logic        spaced;
   logic [4:0]  shift_acc;
   logic [2:0]  count_acc;

   assign serial_write = step && (access.command == CMD_CPU_WRITE) && access.address[15];
   assign spaced       = ({1'b0, last_ff} + 33'd1) < {1'b0, access.cycle};
   assign shift_acc    = shift_ff | (5'(access.data[0]) << count_ff);
   assign count_acc    = count_ff + 3'd1;

   always_comb begin
      banks_in = banks_ff;
      shift_in = shift_ff;
      count_in = count_ff;
      last_in  = last_ff;
      loaded   = 1'b0;
      if (serial_write) begin
         if (access.data[7]) begin
            shift_in         = 5'd0;
            count_in         = 3'd0;
            banks_in.control = banks_ff.control | PRG_MODE_3;
         end else begin
            last_in = access.cycle;
            if (spaced) begin
               shift_in = shift_acc;
               count_in = count_acc;
               if (count_acc == SHIFT_DONE) begin
                  loaded   = 1'b1;
                  shift_in = 5'd0;
                  count_in = 3'd0;
                  unique case (access.address[14:13])
                     SEL_CONTROL:  banks_in.control  = shift_acc;
                     SEL_CHR_LOW:  banks_in.chr_low  = shift_acc;
                     SEL_CHR_HIGH: banks_in.chr_high = shift_acc;
                     SEL_PRG_PAGE: banks_in.prg_page = shift_acc;
                  endcase
               end
            end
         end
      end
   end

   assign banks        = banks_ff;
   assign control_next = banks_in.control;

   always_ff @(posedge clock) begin
      if (reset) begin
         banks_ff.control  <= CONTROL_RESET;
         banks_ff.chr_low  <= 5'd0;
         banks_ff.chr_high <= 5'd0;
         banks_ff.prg_page <= 5'd0;
         shift_ff          <= 5'd0;
         count_ff          <= 3'd0;
         last_ff           <= 32'd0;
      end else begin
         banks_ff <= banks_in;
         shift_ff <= shift_in;
         count_ff <= count_in;
         last_ff  <= last_in;
      end
   end

endmodule

FILE: design/slbm_decode.sv
module slbm_decode
   import slbm_pkg::*;
(
   input  access_type             access,
   input  cfg_type                cfg,
   input  bank_type               banks,
   output logic [2:0]             target,
   output logic [MEM_ADDR_W-1:0]  mem_address,
   output logic                   mem_write
);

   logic [15:0]           a;
   logic                  is_write;
   logic [3:0]            total;
   logic [1:0]            ram_bank;
   logic [15:0]           ram_off;
   logic [15:0]           ram_size;
   logic                  has_ram;
   logic                  has_nvram;
   logic                  ext;
   logic [4:0]            rom_bank;
   logic [4:0]            low_fixed;
   logic [4:0]            lmask;
   logic [5:0]            last_full;
   logic [4:0]            high_fixed;
   logic [MEM_ADDR_W-1:0] rom_off;
   logic [4:0]            chr_sel;
   logic [16:0]           chr_off;

   assign a         = access.address;
   assign is_write  = access.command[0];
   assign total     = {1'b0, cfg.prg_ram_banks} + {1'b0, cfg.prg_nvram_banks};
   assign has_ram   = cfg.prg_ram_banks != 3'd0;
   assign has_nvram = cfg.prg_nvram_banks != 3'd0;
   assign ram_size  = {cfg.prg_ram_banks, 13'd0};
   assign ram_off   = {1'b0, ram_bank, a[12:0]};

   always_comb begin
      if (cfg.ram_layout) begin
         ram_bank = {1'b0, banks.chr_low[4]};
      end else if (total == 4'd2) begin
         ram_bank = {1'b0, banks.chr_low[3]};
      end else if (total == 4'd4) begin
         ram_bank = banks.chr_low[3:2];
      end else begin
         ram_bank = 2'd0;
      end
   end

   assign ext        = (cfg.prg_rom_banks == 6'd32) && banks.chr_low[4];
   assign low_fixed  = {ext, 4'd0};
   assign lmask      = {ext, 4'hF};
   assign last_full  = cfg.prg_rom_banks - 6'd1;
   assign high_fixed = last_full[4:0] & lmask;

   always_comb begin
      rom_bank = {ext, banks.prg_page[3:0]};
      rom_off  = {rom_bank[4:1], a[14:0]};
      case (banks.control[3:2])
         2'd2: begin
            if (a < 16'hC000) rom_bank = low_fixed;
            rom_off = {rom_bank, a[13:0]};
         end
         2'd3: begin
            if (a >= 16'hC000) rom_bank = high_fixed;
            rom_off = {rom_bank, a[13:0]};
         end
         default: rom_off = {rom_bank[4:1], a[14:0]};
      endcase
   end

   assign chr_sel = (a[12] ? banks.chr_high : banks.chr_low) & cfg.chr_mask;

   always_comb begin
      if (!banks.control[4]) begin
         chr_off = {banks.chr_low[4:1] & cfg.chr_mask[4:1], a[12:0]};
      end else begin
         chr_off = {chr_sel, a[11:0]};
      end
   end

   always_comb begin
      target      = TGT_NONE;
      mem_address = '0;
      mem_write   = 1'b0;
      if (!access.command[1]) begin
         if (a < 16'h6000) begin
            target = TGT_NONE;
         end else if (a < 16'h8000) begin
            if (has_ram && has_nvram) begin
               mem_write = is_write;
               if (ram_off >= ram_size) begin
                  target      = TGT_NVRAM;
                  mem_address = {3'd0, ram_off - ram_size};
               end else begin
                  target      = TGT_PRG_RAM;
                  mem_address = {3'd0, ram_off};
               end
            end else if (has_nvram) begin
               target      = TGT_NVRAM;
               mem_address = {3'd0, ram_off};
               mem_write   = is_write;
            end else if (has_ram) begin
               target      = TGT_PRG_RAM;
               mem_address = {3'd0, ram_off};
               mem_write   = is_write;
            end else begin
               target = is_write ? TGT_NONE : TGT_OPEN_BUS;
            end
         end else if (!is_write) begin
            target      = TGT_PRG_ROM;
            mem_address = rom_off & PRG_MASK;
         end else begin
            target = TGT_MAPPER;
         end
      end else begin
         if (a < 16'h2000) begin
            target      = TGT_CHR;
            mem_address = {2'd0, chr_off & CHR_MASK};
            mem_write   = is_write;
         end else if (a < 16'h3F00) begin
            target      = TGT_NAMETABLE;
            mem_address = {6'd0, a[12:0]};
            mem_write   = is_write;
         end else begin
            target = TGT_NONE;
         end
      end
   end

endmodule

FILE: design/serial_loaded_bank_mapper_top.sv
// An accepted item is held in the input register and moves to the result register
// once that register is empty or is being taken by the receiver.
// Throughput: one item per cycle while the receiver takes each result, set by the single
// input register to result register pass; the mapper state is updated in the same pass.
// Reset is synchronous and active high; it restores all configuration and
// mapper registers to their defaults and empties both stages.
module serial_loaded_bank_mapper_top
   import slbm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // address[15:0], data[23:16], cycle[55:24]
   input  logic [1:0]  req_tuser,  // command[1:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,  // mem_address[18:0], mem_write[19], mirroring[21:20],
                                   // register_loaded[22], zero[23]
   output logic [2:0]  rsp_tuser,  // target[2:0]
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   cfg_type               cfg;
   bank_type              banks;
   logic [4:0]            control_next;
   logic                  loaded;
   logic [2:0]            target;
   logic [MEM_ADDR_W-1:0] mem_address;
   logic                  mem_write;
   logic                  advance;

   logic                  in_valid_ff;
   access_type            in_item_ff;
   logic                  out_valid_ff;
   logic [2:0]            out_target_ff;
   logic [MEM_ADDR_W-1:0] out_address_ff;
   logic                  out_write_ff;
   logic [1:0]            out_mirror_ff;
   logic                  out_loaded_ff;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   slbm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   slbm_bank_regs u_bank_regs (
      .clock        (clock),
      .reset        (reset),
      .step         (advance),
      .access       (in_item_ff),
      .banks        (banks),
      .control_next (control_next),
      .loaded       (loaded)
   );

   slbm_decode u_decode (
      .access      (in_item_ff),
      .cfg         (cfg),
      .banks       (banks),
      .target      (target),
      .mem_address (mem_address),
      .mem_write   (mem_write)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) in_valid_ff <= req_tvalid;
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_item_ff.command <= req_tuser;
         in_item_ff.address <= req_tdata[15:0];
         in_item_ff.data    <= req_tdata[23:16];
         in_item_ff.cycle   <= req_tdata[55:24];
      end
      if (advance) begin
         out_target_ff  <= target;
         out_address_ff <= mem_address;
         out_write_ff   <= mem_write;
         out_mirror_ff  <= control_next[1:0];
         out_loaded_ff  <= loaded;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_target_ff;
   assign rsp_tdata  = {1'b0, out_loaded_ff, out_mirror_ff, out_write_ff, out_address_ff};

endmodule
